// File: hdl/slcd_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// sync/length/checksum deframer. No dependencies.
`default_nettype none

package slcd_pkg;

  // Frame fill limit and frame store size
  localparam int FILL_LIMIT  = 40;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Fixed field widths
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Frame layout: sync, sync, function, length, payload..., checksum
  localparam logic [COUNT_W-1:0] POS_SYNC_FIRST  = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS_SYNC_SECOND = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS_FUNCTION    = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_LENGTH      = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] SYNC_RESTART_COUNT = COUNT_W'(2);
  localparam int PAYLOAD_BASE   = 4;
  localparam int FRAME_OVERHEAD = 5;

  // Register reset values
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hAF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SYNC_SECOND = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_SUM_ERR = 2'd2,
    KIND_HDR_ERR = 2'd3
  } slcd_kind_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } slcd_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic step;          // apply the accepted input byte
    logic rd_issue;      // read the next payload byte from the store
    logic emit_payload;  // load the payload result into the output register
  } slcd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_payload; // the current byte completes a good, non-empty frame
    logic idx_last;      // the payload byte at hand is the final one
    logic out_free;      // the output register can take a result this cycle
  } slcd_stat_t;

endpackage

`default_nettype wire

// File: hdl/slcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module slcd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/slcd_dpath.sv
// Deframer datapath: sync registers, fill count, running checksum, header
// shadows, frame store RAM and output register. Uses slcd_pkg and slcd_ram.
`default_nettype none

module slcd_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [slcd_pkg::BYTE_W-1:0]          in_rx_byte,
  input  wire logic                                 cfg_we,
  input  wire logic [slcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [slcd_pkg::BYTE_W-1:0]          cfg_data,
  input  wire logic                                 out_stall,
  output logic                                      out_valid,
  output logic      [slcd_pkg::KIND_W-1:0]          out_kind,
  output logic      [slcd_pkg::BYTE_W-1:0]          out_function_code,
  output logic      [slcd_pkg::BYTE_W-1:0]          out_payload_byte,
  output logic      [slcd_pkg::INDEX_W-1:0]         out_byte_index,
  output logic                                      out_last,
  input  wire slcd_pkg::slcd_cmd_t                  cmd,
  output slcd_pkg::slcd_stat_t                      stat
);

  localparam int POS_W = slcd_pkg::ADDR_W + 1 > slcd_pkg::COUNT_W + 1 ?
                         slcd_pkg::ADDR_W + 1 : slcd_pkg::COUNT_W + 1;

  logic [slcd_pkg::BYTE_W-1:0]  sync_first_r, sync_first_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  sync_second_r, sync_second_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  prev_r, prev_nxt;
  logic [slcd_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  hdr0_r, hdr0_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  hdr1_r, hdr1_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  func_r, func_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  len_r, len_nxt;
  logic [slcd_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic                         rd_oob_r, rd_oob_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [slcd_pkg::KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  out_func_r, out_func_nxt;
  logic [slcd_pkg::BYTE_W-1:0]  out_pay_r, out_pay_nxt;
  logic [slcd_pkg::INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic                         out_last_r, out_last_nxt;

  logic                         is_sync;
  logic [slcd_pkg::COUNT_W-1:0] cnt_inc;
  logic                         cnt_wrap;
  logic [slcd_pkg::COUNT_W-1:0] cnt_app;
  logic                         complete;
  logic                         sum_ok;
  logic                         hdr_ok;
  logic                         out_free;
  logic                         start_payload;
  logic [POS_W-1:0]             wr_pos;
  logic [POS_W-1:0]             rd_pos;
  logic                         ram_wr_en;
  logic                         ram_rd_en;
  logic [slcd_pkg::BYTE_W-1:0]  ram_rd_data;
  slcd_pkg::slcd_kind_t         done_kind;

  // Frame state evaluation for the byte at the input
  always_comb begin
    is_sync  = (prev_r == sync_first_r) && (in_rx_byte == sync_second_r);
    cnt_inc  = count_r + slcd_pkg::COUNT_W'(1);
    cnt_wrap = cnt_inc > slcd_pkg::COUNT_W'(slcd_pkg::FILL_LIMIT);
    cnt_app  = cnt_wrap ? '0 : cnt_inc;
    complete = !is_sync && (cnt_app > slcd_pkg::POS_LENGTH) &&
               ({3'b000, cnt_app} ==
                ({1'b0, len_r} + 9'(slcd_pkg::FRAME_OVERHEAD)));
    // Running sum covers every stored byte before the checksum byte
    sum_ok   = sum_r == in_rx_byte;
    hdr_ok   = (hdr0_r == sync_first_r) && (hdr1_r == sync_second_r);
    out_free = !out_valid_r || !out_stall;
    start_payload = complete && sum_ok && hdr_ok && (len_r != '0);
    if (!sum_ok) begin
      done_kind = slcd_pkg::KIND_SUM_ERR;
    end else if (!hdr_ok) begin
      done_kind = slcd_pkg::KIND_HDR_ERR;
    end else begin
      done_kind = slcd_pkg::KIND_EMPTY;
    end
    wr_pos = POS_W'(count_r);
    rd_pos = POS_W'(slcd_pkg::PAYLOAD_BASE) + POS_W'(idx_r);
  end

  // Drop store writes and reads beyond the store
  assign ram_wr_en = cmd.step && !is_sync &&
                     (wr_pos < POS_W'(slcd_pkg::STORE_DEPTH));
  assign ram_rd_en = cmd.rd_issue && (rd_pos < POS_W'(slcd_pkg::STORE_DEPTH));

  // Configuration, frame tracking and payload index
  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    prev_nxt   = prev_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    hdr0_nxt   = hdr0_r;
    hdr1_nxt   = hdr1_r;
    func_nxt   = func_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    rd_oob_nxt = rd_oob_r;

    if (cfg_we) begin
      case (cfg_index)
        slcd_pkg::CFG_IDX_SYNC_FIRST:  sync_first_nxt  = cfg_data;
        slcd_pkg::CFG_IDX_SYNC_SECOND: sync_second_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.step) begin
      prev_nxt = in_rx_byte;
      idx_nxt  = '0;
      if (is_sync) begin
        // Restart the frame with both sync bytes in place
        count_nxt = slcd_pkg::SYNC_RESTART_COUNT;
        sum_nxt   = sync_first_r + sync_second_r;
        hdr0_nxt  = sync_first_r;
        hdr1_nxt  = sync_second_r;
      end else begin
        // Append the byte and keep header shadows up to date
        count_nxt = cnt_app;
        sum_nxt   = cnt_wrap ? '0 : sum_r + in_rx_byte;
        if (count_r == slcd_pkg::POS_SYNC_FIRST)  hdr0_nxt = in_rx_byte;
        if (count_r == slcd_pkg::POS_SYNC_SECOND) hdr1_nxt = in_rx_byte;
        if (count_r == slcd_pkg::POS_FUNCTION)    func_nxt = in_rx_byte;
        if (count_r == slcd_pkg::POS_LENGTH)      len_nxt  = in_rx_byte;
      end
    end

    if (cmd.rd_issue) begin
      rd_oob_nxt = !ram_rd_en;
    end
    if (cmd.emit_payload) begin
      idx_nxt = idx_r + slcd_pkg::INDEX_W'(1);
    end
  end

  // Output register: load a finished result, drain when taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_func_nxt  = out_func_r;
    out_pay_nxt   = out_pay_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    if (cmd.step && complete && !start_payload) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = done_kind;
      out_func_nxt  = func_r;
      out_pay_nxt   = '0;
      out_idx_nxt   = '0;
      out_last_nxt  = 1'b1;
    end else if (cmd.emit_payload) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = slcd_pkg::KIND_PAYLOAD;
      out_func_nxt  = func_r;
      out_pay_nxt   = rd_oob_r ? '0 : ram_rd_data;
      out_idx_nxt   = idx_r;
      out_last_nxt  = stat.idx_last;
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= slcd_pkg::SYNC_FIRST_RESET;
      sync_second_r <= slcd_pkg::SYNC_SECOND_RESET;
      prev_r        <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      prev_r        <= prev_nxt;
      count_r       <= count_nxt;
      sum_r         <= sum_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hdr0_r     <= hdr0_nxt;
    hdr1_r     <= hdr1_nxt;
    func_r     <= func_nxt;
    len_r      <= len_nxt;
    idx_r      <= idx_nxt;
    rd_oob_r   <= rd_oob_nxt;
    out_kind_r <= out_kind_nxt;
    out_func_r <= out_func_nxt;
    out_pay_r  <= out_pay_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  // Frame store
  slcd_ram #(
    .WIDTH (slcd_pkg::BYTE_W),
    .DEPTH (slcd_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_pos[slcd_pkg::ADDR_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_pos[slcd_pkg::ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  // Status to the controller
  always_comb begin
    stat.start_payload = start_payload;
    stat.idx_last      = ({2'b00, idx_r} + 8'd1) == len_r;
    stat.out_free      = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_function_code = out_func_r;
  assign out_payload_byte  = out_pay_r;
  assign out_byte_index    = out_idx_r;
  assign out_last          = out_last_r;

  // Fill count never passes the fill limit
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slcd_pkg::COUNT_W'(slcd_pkg::FILL_LIMIT))
    else $error("fill count above limit");

  // A payload result is loaded only when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_payload |-> out_free)
    else $error("payload emitted into a busy output register");

  // A sync pair restarts the count at two
  a_sync_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && is_sync) |=> (count_r == slcd_pkg::SYNC_RESTART_COUNT))
    else $error("sync pair did not restart the frame");

endmodule

`default_nettype wire

// File: hdl/slcd_ctrl.sv
// Deframer controller: accepts input bytes and sequences the payload
// readout from the frame store. Uses slcd_pkg.
`default_nettype none

module slcd_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire slcd_pkg::slcd_stat_t  stat,
  output slcd_pkg::slcd_cmd_t        cmd
);

  slcd_pkg::slcd_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt        = state_r;
    cmd.step         = 1'b0;
    cmd.rd_issue     = 1'b0;
    cmd.emit_payload = 1'b0;
    in_stall         = 1'b1;
    case (state_r)
      slcd_pkg::ST_IDLE: begin
        // Take a request when any result it makes has room
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.start_payload) begin
            state_nxt = slcd_pkg::ST_READ;
          end
        end
      end
      slcd_pkg::ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = slcd_pkg::ST_WAIT;
      end
      slcd_pkg::ST_WAIT: begin
        // Hold read data until the output register frees up
        if (stat.out_free) begin
          cmd.emit_payload = 1'b1;
          state_nxt = stat.idx_last ? slcd_pkg::ST_IDLE : slcd_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = slcd_pkg::ST_IDLE;
      end
    endcase
  end

  // Read issue is always followed by the wait for its data
  a_read_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slcd_pkg::ST_READ) |=> (state_r == slcd_pkg::ST_WAIT))
    else $error("read not followed by wait");

  // A good non-empty frame starts the payload readout
  a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.start_payload) |=> (state_r == slcd_pkg::ST_READ))
    else $error("payload readout did not start");

  // The final payload byte returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_payload && stat.idx_last) |=> (state_r == slcd_pkg::ST_IDLE))
    else $error("controller did not return to idle after last byte");

  // No request is taken while the payload readout runs
  a_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != slcd_pkg::ST_IDLE) |-> (!cmd.step && in_stall))
    else $error("request taken during readout");

endmodule

`default_nettype wire

// File: hdl/sync_length_checksum_deframer.sv
// Top level of the sync/length/checksum deframer: joins controller and
// datapath. Uses slcd_pkg, slcd_ctrl and slcd_dpath.
//
// Usage: received serial bytes enter on the in_ channel (in_valid,
// in_stall, in_rx_byte). A frame is sync_first, sync_second, function,
// length L, L payload bytes and an additive checksum byte. Results leave
// on the out_ channel: one result per payload byte of a good frame, or
// a single empty, checksum-error or header-error result, last marking
// the end of each run. cfg_we/cfg_index/cfg_data write the two sync bytes.
// Flow: a byte that completes no good non-empty frame is taken while the
// output register is free; a byte completing a frame with L payload bytes
// is followed by a READ and a WAIT state per payload byte, set by the frame
// store RAM's registered read, and no new byte is taken meanwhile.
// A result enters the output register in the cycle after it is produced.
// Reset: sync bytes return to 0xAA/0xAF, fill count and previous byte to
// zero; the frame store is not cleared.
// Stall: a stalled result holds in the output register; the next byte or
// payload result waits until it is taken.
`default_nettype none

module sync_length_checksum_deframer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [slcd_pkg::BYTE_W-1:0]        in_rx_byte,
  input  wire logic                               cfg_we,
  input  wire logic [slcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [slcd_pkg::BYTE_W-1:0]        cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [slcd_pkg::KIND_W-1:0]        out_kind,
  output logic      [slcd_pkg::BYTE_W-1:0]        out_function_code,
  output logic      [slcd_pkg::BYTE_W-1:0]        out_payload_byte,
  output logic      [slcd_pkg::INDEX_W-1:0]       out_byte_index,
  output logic                                    out_last
);

  slcd_pkg::slcd_cmd_t  cmd;
  slcd_pkg::slcd_stat_t stat;

  // Controller
  slcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  slcd_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_function_code (out_function_code),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_last          (out_last),
    .cmd               (cmd),
    .stat              (stat)
  );

endmodule

`default_nettype wire

// File: tb/sv/deframer_scoreboard_pkg.sv
// Scoreboard for the sync/length/checksum deframer: predicts the result
// stream from accepted bytes and checks results in order.
// Depends on slcd_pkg for widths, frame layout constants and result kinds.
package deframer_scoreboard_pkg;

  import slcd_pkg::*;

  // One result as it leaves the out_ channel
  typedef struct {
    slcd_kind_t          kind;
    logic [BYTE_W-1:0]   function_code;
    logic [BYTE_W-1:0]   payload_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic                last;
  } frame_result_t;

  class deframer_scoreboard;
    logic [BYTE_W-1:0]  sync_first;
    logic [BYTE_W-1:0]  sync_second;
    logic [BYTE_W-1:0]  prev_byte;
    logic [COUNT_W-1:0] fill;
    bit [BYTE_W-1:0]    store [STORE_DEPTH];
    frame_result_t      due_results [$];
    int                 failures;

    function new();
      sync_first  = SYNC_FIRST_RESET;
      sync_second = SYNC_SECOND_RESET;
      prev_byte   = '0;
      fill        = '0;
      failures    = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Advance the frame state by one accepted byte and queue what it completes
    function void absorb_byte(logic [BYTE_W-1:0] rx);
      logic [COUNT_W-1:0] next_fill;
      logic [BYTE_W-1:0]  sum;
      logic [BYTE_W-1:0]  len;
      frame_result_t      r;
      int                 n;
      int                 i;
      n = 0;
      if (prev_byte == sync_first && rx == sync_second) begin
        // Restart the frame on the sync pair; never completes here
        fill = SYNC_RESTART_COUNT;
        store[POS_SYNC_FIRST]  = sync_first;
        store[POS_SYNC_SECOND] = sync_second;
      end else begin
        store[fill] = rx;
        next_fill = fill + 1'b1;
        if (int'(next_fill) > FILL_LIMIT) next_fill = '0;
        fill = next_fill;
        if (fill > POS_LENGTH && int'(fill) == int'(store[POS_LENGTH]) + FRAME_OVERHEAD)
          n = int'(fill);
      end
      prev_byte = rx;
      if (n == 0) return;

      // Check the completed frame: checksum first, then header
      len = store[POS_LENGTH];
      sum = '0;
      for (i = 0; i < n - 1; i++) sum += store[i];
      r.function_code = store[POS_FUNCTION];
      r.payload_byte  = '0;
      r.byte_index    = '0;
      r.last          = 1'b1;
      if (sum != store[n-1]) begin
        r.kind = KIND_SUM_ERR;
        due_results.push_back(r);
      end else if (store[POS_SYNC_FIRST] != sync_first ||
                   store[POS_SYNC_SECOND] != sync_second) begin
        r.kind = KIND_HDR_ERR;
        due_results.push_back(r);
      end else if (len == 0) begin
        r.kind = KIND_EMPTY;
        due_results.push_back(r);
      end else begin
        for (i = 0; i < int'(len); i++) begin
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = store[PAYLOAD_BASE + i];
          r.byte_index   = i[INDEX_W-1:0];
          r.last         = (i == int'(len) - 1);
          due_results.push_back(r);
        end
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected 0x%02h, got 0x%02h", $time, field, want, got);
        failures++;
      end
    endfunction

    // Match one accepted result against the oldest prediction
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: kind %0d function 0x%02h payload 0x%02h",
                 $time, got.kind, got.function_code, got.payload_byte);
        failures++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", {6'b0, want.kind}, {6'b0, got.kind});
      compare_field("function_code", want.function_code, got.function_code);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("byte_index", {2'b0, want.byte_index}, {2'b0, got.byte_index});
      compare_field("last", {7'b0, want.last}, {7'b0, got.last});
    endfunction
  endclass

endpackage

// File: tb/sv/tb.sv
// Top-level testbench for sync_length_checksum_deframer: drives framed and
// broken byte streams under random idling and checks every result in order.
// Depends on slcd_pkg, deframer_scoreboard_pkg and the deframer RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slcd_pkg::*;
  import deframer_scoreboard_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int CHUNK_ITEMS   = 80;
  localparam int MAX_PAYLOAD   = FILL_LIMIT - FRAME_OVERHEAD;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    out_kind;
  logic [BYTE_W-1:0]    out_function_code;
  logic [BYTE_W-1:0]    out_payload_byte;
  logic [INDEX_W-1:0]   out_byte_index;
  logic                 out_last;

  deframer_scoreboard board = new();
  int send_idle_pct = 30;
  int recv_idle_pct = 65;
  int hold_reqs = 0;
  int bytes_sent = 0;
  logic [BYTE_W-1:0] burst [$];

  sync_length_checksum_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_function_code (out_function_code),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Take results, check them, and drive stall (random, or a long hold-off)
  initial begin
    int hold_left;
    int hold_seen;
    frame_result_t got;
    hold_left = 0;
    hold_seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.kind          = slcd_kind_t'(out_kind);
        got.function_code = out_function_code;
        got.payload_byte  = out_payload_byte;
        got.byte_index    = out_byte_index;
        got.last          = out_last;
        board.check_result(got);
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Append one frame: header, function, length, random payload, checksum
  function automatic void add_frame(logic [7:0] head0, logic [7:0] head1, logic [7:0] fc,
                                    logic [7:0] len, logic corrupt);
    logic [7:0] sum;
    logic [7:0] data;
    sum = head0 + head1 + fc + len;
    burst.push_back(head0);
    burst.push_back(head1);
    burst.push_back(fc);
    burst.push_back(len);
    repeat (len) begin
      data = 8'($urandom);
      sum += data;
      burst.push_back(data);
    end
    burst.push_back(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
  endfunction

  // Mostly short payloads, some medium, some at the maximum
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'(MAX_PAYLOAD);
    if (r < 20) return 8'($urandom_range(7, MAX_PAYLOAD - 1));
    return 8'($urandom_range(0, 6));
  endfunction

  // Offer each queued byte as one request and hold it until taken
  task automatic send_burst();
    foreach (burst[i]) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= burst[i];
      do @(posedge clk); while (in_stall !== 1'b0);
      board.absorb_byte(burst[i]);
      bytes_sent++;
    end
    burst.delete();
  endtask

  task automatic run_frames(int goal);
    int start;
    int pick;
    int pad;
    logic [7:0] filler;
    start = bytes_sent;
    while (bytes_sent - start < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_frame(board.sync_first, board.sync_second, 8'($urandom), pick_len(), 1'b0);
      end else if (pick < 70) begin
        add_frame(board.sync_first, board.sync_second, 8'($urandom), pick_len(), 1'b1);
      end else if (pick < 76) begin
        // Run the count past the fill limit, then a frame with a foreign header
        pad = FILL_LIMIT + 1 - int'(board.fill);
        repeat (pad) begin
          filler = 8'($urandom);
          if (filler == board.sync_second) filler = ~filler;
          burst.push_back(filler);
        end
        add_frame(board.sync_first ^ 8'($urandom_range(1, 255)), 8'($urandom),
                  8'($urandom), 8'($urandom_range(0, 6)), 1'b0);
      end else if (pick < 86) begin
        // Cut a frame short, with any length byte
        burst.push_back(board.sync_first);
        burst.push_back(board.sync_second);
        burst.push_back(8'($urandom));
        burst.push_back(8'($urandom));
        repeat ($urandom_range(0, 8)) burst.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
      end
      send_burst();
    end
  endtask

  // Drop valid and wait for all predicted results plus settling time
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_sync(logic [7:0] first_sync, logic [7:0] second_sync);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_SYNC_FIRST;
    cfg_data  <= first_sync;
    @(posedge clk);
    cfg_index <= CFG_IDX_SYNC_SECOND;
    cfg_data  <= second_sync;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.sync_first  = first_sync;
    board.sync_second = second_sync;
  endtask

  initial begin
    logic [7:0] same_sync;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_IDX_SYNC_FIRST;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: header error from the reset position, sync pair landing on
    // the completing byte, empty frame, payload frame, checksum error
    add_frame(8'h12, 8'h34, 8'h00, 8'h00, 1'b0);
    burst.push_back(SYNC_FIRST_RESET);
    burst.push_back(SYNC_SECOND_RESET);
    burst.push_back(8'h00);
    burst.push_back(8'h01);
    add_frame(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'hFF, 8'h00, 1'b0);
    add_frame(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'h00, 8'h02, 1'b0);
    add_frame(SYNC_FIRST_RESET, SYNC_SECOND_RESET, 8'h5A, 8'h00, 1'b1);
    send_burst();

    // Reset sync bytes, sender idles lightly, receiver heavily
    run_frames(CHUNK_ITEMS);
    finish_phase();

    // Low/high sync bytes, idling swapped, long receiver hold-off up front
    program_sync(8'h00, 8'hFF);
    send_idle_pct = 65;
    recv_idle_pct <= 30;
    hold_reqs <= hold_reqs + 1;
    add_frame(8'h00, 8'hFF, 8'($urandom), 8'(MAX_PAYLOAD), 1'b0);
    send_burst();
    run_frames(CHUNK_ITEMS);
    finish_phase();

    // High/low sync bytes, no idling
    program_sync(8'hFF, 8'h00);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_frames(CHUNK_ITEMS);
    finish_phase();

    // Identical sync bytes
    same_sync = 8'($urandom);
    program_sync(same_sync, same_sync);
    run_frames(CHUNK_ITEMS);
    finish_phase();

    if (board.failures == 0 && board.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
